// ----- src/b2s_pkg.sv -----
// Package for binary_to_sexagesimal_digits: payload structs, controller/datapath
// command and status structs, digit kinds and divide-by-60 constants.
// No dependencies.
package b2s_pkg;

  localparam int FRACTION_BITS_DEF       = 32;
  localparam int MAX_FRACTION_DIGITS_DEF = 16;

  localparam int INT_W      = 64;
  localparam int FRAC_IN_W  = 32;
  localparam int DIGIT_W    = 6;
  localparam int KIND_W     = 2;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

  localparam int RADIX      = 60;
  localparam int INT_DIGITS = 11;
  localparam int INT_CNT_W  = $clog2(INT_DIGITS + 1);

  // Integer is divided by 60 one 16-bit chunk per cycle, MSB chunk first
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNKS  = INT_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS);

  // floor(2^28 / 60); exact to within one for a 22-bit dividend
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 23;
  localparam int RECIP       = (1 << RECIP_SHIFT) / RADIX;

  localparam logic [KIND_W-1:0] KIND_INT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRAC  = 2'd2;

  typedef struct packed {
    logic [INT_W-1:0]     integer_value;
    logic [FRAC_IN_W-1:0] fraction_value;
    logic                 has_point;
  } number_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [KIND_W-1:0]  digit_kind;
    logic               last;
  } result_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic chunk_last;
    logic emit_int;
    logic emit_point;
    logic emit_frac;
  } b2s_cmd_t;

  typedef struct packed {
    logic div_done;
    logic int_last;
    logic has_point;
    logic point_last;
    logic frac_last;
  } b2s_status_t;

endpackage

// ----- src/binary_to_sexagesimal_digits.sv -----
// Top level of the binary to base-60 digit converter.
// Depends on b2s_pkg, b2s_ctrl and b2s_datapath.
//
// Usage:
//   A number is transferred on the edge where start is high and busy is low.
//   Digits come out on result, one per result_valid strobe, integer digits
//   most significant first, then (if has_point) the point marker, then up to
//   min(cfg, MAX_FRACTION_DIGITS) fractional digits. result.last marks the
//   final digit of a number. The receiver cannot stall: each strobe lasts one
//   cycle.
//   cfg_we/cfg_wdata write the fractional digit limit (reset value 3); write
//   it only while busy is low.
// Sequence:
//   The integer goes through the divide-by-60 unit 16 bits per cycle, one
//   integer digit per full pass; after that one digit leaves per cycle.
//   The last strobe lands in the cycle busy drops, when the next number can
//   already be taken.
// Reset (synchronous, rst high) returns the controller to idle, drops the
// strobe and sets the digit limit to 3.
module binary_to_sexagesimal_digits import b2s_pkg::*; #(
  parameter int FRACTION_BITS       = FRACTION_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  number_t          number,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             result_valid,
  output result_t          result
);

  b2s_cmd_t    cmd;
  b2s_status_t status;

  b2s_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  b2s_datapath #(
    .FRACTION_BITS       (FRACTION_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .number       (number),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

  // a transfer always starts a division pass
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  // every strobe comes out of a conversion in progress
  a_valid_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without conversion");

  // last digit coincides with the controller going idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("last digit while still busy");

  // point marker carries digit 0, other digits stay below the radix
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.digit < 6'd60) &&
                     (result.digit_kind != KIND_POINT || result.digit == 6'd0))
    else $error("digit out of range");

endmodule

// ----- src/b2s_datapath.sv -----
// Datapath: integer shift register with divide-by-60 chunk unit, digit store,
// fraction times-60 unit, config register and the registered result output.
// Depends on b2s_pkg.
module b2s_datapath import b2s_pkg::*; #(
  parameter int FRACTION_BITS       = FRACTION_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  number_t            number,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  b2s_cmd_t           cmd,
  output b2s_status_t        status,
  output logic               result_valid,
  output result_t            result
);

  localparam int FC_W   = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int X_W    = DIGIT_W + CHUNK_W;
  localparam int DP_W   = X_W + RECIP_W;
  localparam int FP_W   = FRACTION_BITS + DIGIT_W;
  localparam int FX_W   = (FRACTION_BITS > FRAC_IN_W) ? FRACTION_BITS : FRAC_IN_W;
  localparam int IDX_W  = $clog2(INT_DIGITS);

  logic [INT_W-1:0]         shreg;
  logic [DIGIT_W-1:0]       rem;
  logic [INT_CNT_W-1:0]     int_cnt;
  logic [FRACTION_BITS-1:0] frac;
  logic [FC_W-1:0]          fcnt;
  logic                     has_point;
  logic [CFG_W-1:0]         cfg_reg;
  logic [DIGIT_W-1:0]       store [INT_DIGITS];

  // divide-by-60 of one chunk
  logic [X_W-1:0]     div_x;
  logic [DP_W-1:0]    div_prod;
  logic [CHUNK_W-1:0] q_est;
  logic [X_W-1:0]     q_ext;
  logic [X_W-1:0]     r_full;
  logic [DIGIT_W:0]   r_est;
  logic               r_fix;
  logic [CHUNK_W-1:0] q_chunk;
  logic [DIGIT_W-1:0] r_dig;
  logic [INT_W-1:0]   shreg_next;

  // fraction times 60
  logic [FP_W-1:0]          fprod;
  logic [DIGIT_W-1:0]       f_dig;
  logic [FRACTION_BITS-1:0] f_rem;
  logic [FX_W-1:0]          frac_in;

  logic [FC_W-1:0]    limit;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;

  assign div_x    = {rem, shreg[INT_W-1 -: CHUNK_W]};
  assign div_prod = DP_W'(div_x) * DP_W'(RECIP);
  assign q_est    = div_prod[RECIP_SHIFT +: CHUNK_W];
  assign q_ext    = X_W'(q_est);
  assign r_full   = div_x - ((q_ext << 6) - (q_ext << 2));
  assign r_est    = r_full[DIGIT_W:0];
  assign r_fix    = (r_est >= (DIGIT_W+1)'(RADIX));
  assign q_chunk  = r_fix ? q_est + CHUNK_W'(1) : q_est;
  assign r_dig    = r_fix ? DIGIT_W'(r_est - (DIGIT_W+1)'(RADIX)) : r_est[DIGIT_W-1:0];
  assign shreg_next = {shreg[INT_W-CHUNK_W-1:0], q_chunk};

  assign fprod = (FP_W'(frac) << 6) - (FP_W'(frac) << 2);
  assign f_dig = fprod[FP_W-1 -: DIGIT_W];
  assign f_rem = fprod[FRACTION_BITS-1:0];
  assign frac_in = FX_W'(number.fraction_value);

  assign limit  = (int'(cfg_reg) > MAX_FRACTION_DIGITS) ? FC_W'(MAX_FRACTION_DIGITS)
                                                        : FC_W'(cfg_reg);
  assign rd_idx = IDX_W'(int_cnt - INT_CNT_W'(1));
  assign wr_idx = IDX_W'(int_cnt);

  assign status.div_done   = (shreg_next == '0) ||
                             (int_cnt == INT_CNT_W'(INT_DIGITS - 1));
  assign status.int_last   = (int_cnt == INT_CNT_W'(1));
  assign status.has_point  = has_point;
  assign status.point_last = (frac == '0) || (limit == '0);
  assign status.frac_last  = (f_rem == '0) ||
                             ({1'b0, fcnt} + (FC_W+1)'(1) == {1'b0, limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_reg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_cnt <= '0;
      fcnt    <= '0;
      rem     <= '0;
    end else if (cmd.load) begin
      shreg     <= number.integer_value;
      frac      <= frac_in[FRACTION_BITS-1:0];
      has_point <= number.has_point;
      int_cnt   <= '0;
      fcnt      <= '0;
      rem       <= '0;
    end else if (cmd.div_step) begin
      shreg <= shreg_next;
      if (cmd.chunk_last) begin
        // remainder of the full 64-bit division is the next digit
        store[wr_idx] <= r_dig;
        int_cnt       <= int_cnt + INT_CNT_W'(1);
        rem           <= '0;
      end else begin
        rem <= r_dig;
      end
    end else if (cmd.emit_int) begin
      int_cnt <= int_cnt - INT_CNT_W'(1);
    end else if (cmd.emit_frac) begin
      frac <= f_rem;
      fcnt <= fcnt + FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_int | cmd.emit_point | cmd.emit_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_int) begin
      result.digit      <= store[rd_idx];
      result.digit_kind <= KIND_INT;
      result.last       <= status.int_last & ~has_point;
    end else if (cmd.emit_point) begin
      result.digit      <= '0;
      result.digit_kind <= KIND_POINT;
      result.last       <= status.point_last;
    end else if (cmd.emit_frac) begin
      result.digit      <= f_dig;
      result.digit_kind <= KIND_FRAC;
      result.last       <= status.frac_last;
    end
  end

endmodule

// ----- src/b2s_ctrl.sv -----
// Controller: sequences load, chunked divide, integer digit readout, point
// marker and fractional digits. Drives commands to b2s_datapath.
// Depends on b2s_pkg.
module b2s_ctrl import b2s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  b2s_status_t status,
  output logic        busy,
  output b2s_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_INT   = 3'd2;
  localparam logic [2:0] S_POINT = 3'd3;
  localparam logic [2:0] S_FRAC  = 3'd4;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [CHUNK_CNT_W-1:0] chunk;
  logic [CHUNK_CNT_W-1:0] chunk_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    chunk_next = chunk;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          chunk_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.chunk_last = (chunk == CHUNK_CNT_W'(NUM_CHUNKS - 1));
        chunk_next     = chunk + CHUNK_CNT_W'(1);
        if (cmd.chunk_last && status.div_done) begin
          state_next = S_INT;
        end
      end
      S_INT: begin
        cmd.emit_int = 1'b1;
        if (status.int_last) begin
          state_next = status.has_point ? S_POINT : S_IDLE;
        end
      end
      S_POINT: begin
        cmd.emit_point = 1'b1;
        state_next     = status.point_last ? S_IDLE : S_FRAC;
      end
      S_FRAC: begin
        cmd.emit_frac = 1'b1;
        if (status.frac_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chunk <= '0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
    end
  end

endmodule
